@@ hw/rtl/cld_pkg.sv @@
// cld_pkg: shared constants, codes and ring index helpers for the circular list deque
// depends on nothing; used by the interfaces, the core rtl and the testbench

package cld_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_END   = 3'd1,
        MODE_REM_FRONT = 3'd2,
        MODE_REM_END   = 3'd3,
        MODE_REM_AFTER = 3'd4,
        MODE_CLEAR     = 3'd5,
        MODE_READ_ALL  = 3'd6
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_NOKEY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIN,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_REM_RD,
        ST_REM_CAP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RD_ISSUE,
        ST_RD_EMIT
    } state_t;

    // (base + off) mod CAPACITY, off never above CAPACITY
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    // (base - 1) mod CAPACITY
    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] r;
        if (base == '0)
        begin
            r = IDX_W'(CAPACITY - 1);
        end
        else
        begin
            r = base - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/cld_req_if.sv @@
// cld_req_if: request channel of the circular list deque (valid, ready, mode, value)
// depends on cld_pkg for field widths

interface cld_req_if;
    logic                                valid;
    logic                                ready;
    logic [cld_pkg::MODE_W-1:0]          mode;
    logic signed [cld_pkg::DATA_W-1:0]   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

@@ hw/rtl/cld_rsp_if.sv @@
// cld_rsp_if: result channel of the circular list deque (valid, ready, status, data, last)
// depends on cld_pkg for field widths

interface cld_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [cld_pkg::STAT_W-1:0]          status;
    logic signed [cld_pkg::DATA_W-1:0]   data;
    logic                                last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

@@ hw/rtl/cld_ram.sv @@
// cld_ram: generic single write port, single read port ram with registered read
// no dependencies

module cld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/circular_list_deque_core.sv @@
// circular_list_deque_core: top level of the bounded circular list deque
// depends on cld_pkg, cld_req_if, cld_rsp_if and cld_ram
//
// usage
//   req channel (valid/ready): one transaction is one request, mode plus value
//   rsp channel (valid/ready): status, data and last; every request gives one
//   transaction with last set, except read-all on a non-empty list which gives
//   one transaction per element in list order, last set on the final one
//   the elements live in one ram of CAPACITY entries with a registered read;
//   head position and count live in flops
// sequencing (steps from request accept to result loaded)
//   insert, clear, status-only replies: decode in idle, then load the result in fin
//   remove front / remove end: ram read, capture of the entry, then fin
//   remove after key: read and compare per entry searched, ram read and capture, read then
//   write per entry moved up, then fin; read all: read issue then emit per element
//   the single ram read port and the read-then-write sequencing set these steps
//   the next request is taken once the result sits in the output register
// reset: rst_n clears head, count, the control state and the output valid;
//   ram contents are left as they are and only entries inside the count are read
// receiver stall: the output register holds its transaction; the block waits
//   only in a step that loads that register (fin, read-all emit) until it frees, then goes on

module circular_list_deque_core (
    input  logic clk,
    input  logic rst_n,
    cld_req_if.sink   req,
    cld_rsp_if.source rsp
);

    import cld_pkg::*;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    // walk index: search position, removal position, read-out position
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [DATA_W-1:0]  key_reg, key_next;
    status_t            res_status_reg, res_status_next;
    logic [DATA_W-1:0]  res_data_reg, res_data_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;

    logic               out_free;
    logic [CNT_W-1:0]   k_plus1;
    logic               req_fire;

    cld_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign k_plus1   = k_reg + CNT_W'(1);
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.last   = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        // reads and writes never share a cycle, so no same-entry hazard
        ram_we    = 1'b0;
        ram_waddr = ring_add(head_reg, k_reg);
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = ring_add(head_reg, k_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    res_status_next = STAT_OK;
                    res_data_next   = '0;
                    state_next      = ST_FIN;
                    k_next          = '0;
                    unique case (req.mode) inside
                        MODE_INS_FRONT, MODE_INS_END:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = req.value;
                                if (req.mode == MODE_INS_FRONT)
                                begin
                                    ram_waddr = ring_dec(head_reg);
                                    head_next = ring_dec(head_reg);
                                end
                                else
                                begin
                                    ram_waddr = ring_add(head_reg, count_reg);
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_REM_FRONT, MODE_REM_END:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                if (req.mode == MODE_REM_END)
                                begin
                                    k_next = count_reg - CNT_W'(1);
                                end
                                state_next = ST_REM_RD;
                            end
                        end
                        MODE_REM_AFTER:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                key_next   = req.value;
                                state_next = ST_SRCH_RD;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        MODE_READ_ALL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_RD_ISSUE;
                            end
                        end
                        default:
                        begin
                            // unused code: plain ok reply
                        end
                    endcase
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_SRCH_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_SRCH_CMP;
            end

            ST_SRCH_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    // successor wraps to the head after the last element
                    k_next     = (k_plus1 == count_reg) ? '0 : k_plus1;
                    state_next = ST_REM_RD;
                end
                else if (k_plus1 == count_reg)
                begin
                    res_status_next = STAT_NOKEY;
                    state_next      = ST_FIN;
                end
                else
                begin
                    k_next     = k_plus1;
                    state_next = ST_SRCH_RD;
                end
            end

            ST_REM_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_REM_CAP;
            end

            ST_REM_CAP:
            begin
                res_status_next = STAT_OK;
                res_data_next   = ram_rdata;
                if (k_reg == '0)
                begin
                    // head leaves: advance head, back to zero when the list empties
                    head_next  = (count_reg == CNT_W'(1)) ? '0 : ring_add(head_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_FIN;
                end
                else if (k_plus1 < count_reg)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_FIN;
                end
            end

            ST_SHIFT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ring_add(head_reg, k_plus1);
                state_next = ST_SHIFT_WR;
            end

            ST_SHIFT_WR:
            begin
                // close the gap: entry k takes entry k+1
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                k_next    = k_plus1;
                if (k_plus1 + CNT_W'(1) < count_reg)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_FIN;
                end
            end

            ST_RD_ISSUE:
            begin
                ram_re     = 1'b1;
                state_next = ST_RD_EMIT;
            end

            ST_RD_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_data_next   = ram_rdata;
                    out_last_next   = (k_plus1 == count_reg);
                    if (k_plus1 == count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_plus1;
                        state_next = ST_RD_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // count stays within the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // an empty list always has its head parked at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0))
        else $error("empty list with nonzero head");

    // the ram is never read and written in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("ram read and write overlap");

    // an insert into a list with room grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.mode == MODE_INS_FRONT || req.mode == MODE_INS_END)
         && (count_reg != CNT_W'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // a result held by a stalled receiver stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> out_valid_reg)
        else $error("pending result dropped");

endmodule

@@ sim/tb_circular_list_deque_core.sv @@
`timescale 1ns / 1ps
// tb_circular_list_deque_core: self-checking testbench of the circular list deque core
// depends on cld_pkg, cld_req_if, cld_rsp_if and the circular_list_deque_core rtl

module tb_circular_list_deque_core;
    import cld_pkg::*;

    // mode 7 has no operation behind it; the block answers it with a plain ok reply
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 80;
    localparam int IDLE_PCT    = 28;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } reply_t;

    logic clk;
    logic rst_n;

    cld_req_if req_bus ();
    cld_rsp_if rsp_bus ();

    circular_list_deque_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // shadow copy of the list: ring, head and count at the block's widths
    logic signed [DATA_W-1:0] shadow_ring [CAPACITY];
    logic [IDX_W-1:0]         shadow_head;
    logic [CNT_W-1:0]         shadow_count;

    // replies still owed by the block, oldest first
    reply_t awaited_replies [$];

    int  error_count;
    int  reply_count;
    int  cycle_count;
    int  mode_tally [8];
    int  status_tally [4];
    bit  src_gaps_on;
    bit  sink_stall_on;

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies still owed",
                     cycle_count, awaited_replies.size());
            $display("tb_circular_list_deque_core failed");
            $finish;
        end
    end

    // result side back-pressure: random stalls while enabled, otherwise always ready
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_stall_on)
            begin
                rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // ring slot of the element at list position pos
    function automatic logic [IDX_W-1:0] slot_of(int unsigned pos);
        return IDX_W'((int'(shadow_head) + pos) % CAPACITY);
    endfunction

    // unlink the element at list position pos; later elements move up by one
    function automatic logic signed [DATA_W-1:0] unlink_at(int unsigned pos);
        logic signed [DATA_W-1:0] v;
        int unsigned k;
        v = shadow_ring[slot_of(pos)];
        if (pos == 0)
        begin
            shadow_head = slot_of(1);
        end
        else
        begin
            for (k = pos; k + 1 < shadow_count; k++)
            begin
                shadow_ring[slot_of(k)] = shadow_ring[slot_of(k + 1)];
            end
        end
        shadow_count = shadow_count - 1'b1;
        if (shadow_count == '0)
        begin
            shadow_head = '0;
        end
        return v;
    endfunction

    // apply one accepted request to the shadow list and queue the replies it owes
    task automatic apply_request(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
        reply_t      r;
        int unsigned k;
        bit          hit;
        r.status = STAT_OK;
        r.data   = '0;
        r.last   = 1'b1;
        mode_tally[m]++;
        case (m)
            MODE_INS_FRONT, MODE_INS_END:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    if (m == MODE_INS_FRONT)
                    begin
                        shadow_head = IDX_W'((int'(shadow_head) + CAPACITY - 1) % CAPACITY);
                        shadow_ring[shadow_head] = v;
                    end
                    else
                    begin
                        shadow_ring[slot_of(shadow_count)] = v;
                    end
                    shadow_count = shadow_count + 1'b1;
                end
                awaited_replies.push_back(r);
            end
            MODE_REM_FRONT, MODE_REM_END:
            begin
                if (shadow_count == '0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.data = unlink_at((m == MODE_REM_FRONT) ? 0 : shadow_count - 1);
                end
                awaited_replies.push_back(r);
            end
            MODE_REM_AFTER:
            begin
                if (shadow_count == '0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    // successor of the first match, taken around the ring
                    hit = 1'b0;
                    for (k = 0; k < shadow_count; k++)
                    begin
                        if (!hit && shadow_ring[slot_of(k)] == v)
                        begin
                            hit    = 1'b1;
                            r.data = unlink_at((k + 1) % shadow_count);
                        end
                    end
                    if (!hit)
                    begin
                        r.status = STAT_NOKEY;
                    end
                end
                awaited_replies.push_back(r);
            end
            MODE_CLEAR:
            begin
                shadow_count = '0;
                shadow_head  = '0;
                awaited_replies.push_back(r);
            end
            MODE_READ_ALL:
            begin
                if (shadow_count == '0)
                begin
                    r.status = STAT_EMPTY;
                    awaited_replies.push_back(r);
                end
                else
                begin
                    for (k = 0; k < shadow_count; k++)
                    begin
                        r.data = shadow_ring[slot_of(k)];
                        r.last = (k + 1 == shadow_count);
                        awaited_replies.push_back(r);
                    end
                end
            end
            default:
            begin
                awaited_replies.push_back(r);
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        error_count++;
        $display("mismatch at %0t on %s: expected 0x%08h got 0x%08h (reply %0d)",
                 $time, field, want, got, reply_count);
    endtask

    // every result transaction is checked against the oldest owed reply
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (awaited_replies.size() == 0)
            begin
                error_count++;
                $display("unexpected result transaction at %0t: status %0d data 0x%08h",
                         $time, rsp_bus.status, rsp_bus.data);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (rsp_bus.status !== want.status)
                begin
                    report_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_bus.status));
                end
                if (rsp_bus.data !== want.data)
                begin
                    report_mismatch("data", want.data, rsp_bus.data);
                end
                if (rsp_bus.last !== want.last)
                begin
                    report_mismatch("last", DATA_W'(want.last), DATA_W'(rsp_bus.last));
                end
                status_tally[want.status]++;
            end
            reply_count++;
        end
    end

    // one request transaction; valid stays up into the next request when no gap follows
    task automatic send_request(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
        while (src_gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.mode  <= m;
        req_bus.value <= v;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        apply_request(m, v);
    endtask

    // hold off new requests until every owed reply has come back
    task automatic drain_replies();
        req_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (awaited_replies.size() != 0);
    endtask

    // some small values so keys repeat, some extremes, most full width
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(9))
            0, 1: v = $signed($urandom_range(8)) - 4;
            2:
            begin
                case ($urandom_range(3))
                    0: v = 32'sh7fff_ffff;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // key that usually sits in the list, so removals after a key get past the search
    function automatic logic signed [DATA_W-1:0] pick_key();
        if (shadow_count != '0 && $urandom_range(99) < 70)
        begin
            return shadow_ring[slot_of($urandom_range(shadow_count - 1))];
        end
        return pick_value();
    endfunction

    // every removal, read-all and clear on an empty list, the unused mode included
    task automatic test_empty_list();
        send_request(MODE_READ_ALL, 0);
        send_request(MODE_REM_FRONT, 0);
        send_request(MODE_REM_END, -1);
        send_request(MODE_REM_AFTER, 0);
        send_request(MODE_CLEAR, 0);
        send_request(MODE_UNUSED, 32'sh1234_5678);
    endtask

    // value extremes, key hits on head, on last and on a lone element, key miss
    task automatic test_field_extremes();
        send_request(MODE_INS_FRONT, 32'sh7fff_ffff);
        send_request(MODE_INS_END, 32'sh8000_0000);
        send_request(MODE_INS_FRONT, 0);
        send_request(MODE_INS_END, -1);
        send_request(MODE_INS_FRONT, 32'sh5555_5555);
        send_request(MODE_READ_ALL, 0);
        send_request(MODE_REM_AFTER, 32'sh0001_2345);
        // match on the head removes its successor
        send_request(MODE_REM_AFTER, 32'sh5555_5555);
        // match on the last element removes the head
        send_request(MODE_REM_AFTER, -1);
        send_request(MODE_UNUSED, -1);
        send_request(MODE_READ_ALL, 0);
        send_request(MODE_REM_FRONT, 0);
        send_request(MODE_REM_END, 0);
        // lone element removes itself
        send_request(MODE_REM_AFTER, 32'sh8000_0000);
        send_request(MODE_READ_ALL, 0);
        send_request(MODE_INS_END, 32'sh2aaa_aaaa);
        send_request(MODE_CLEAR, 0);
        send_request(MODE_REM_END, 0);
    endtask

    // fill to capacity from both ends, overflow both ways, wrap a key hit, clear
    task automatic test_fill_and_full();
        int i;
        send_request(MODE_CLEAR, 0);
        for (i = 0; i < CAPACITY; i++)
        begin
            send_request((i % 2) ? MODE_INS_END : MODE_INS_FRONT, $urandom);
        end
        send_request(MODE_INS_FRONT, 1);
        send_request(MODE_INS_END, 2);
        send_request(MODE_READ_ALL, 0);
        send_request(MODE_REM_AFTER, shadow_ring[slot_of(shadow_count - 1)]);
        send_request(MODE_INS_END, $urandom);
        send_request(MODE_READ_ALL, 0);
        send_request(MODE_CLEAR, 0);
        send_request(MODE_READ_ALL, 0);
        send_request(MODE_REM_FRONT, 0);
    endtask

    // random requests; ins_pct steers how full the list tends to run
    task automatic test_random_traffic(input int count, input int ins_pct);
        int                       i;
        int                       pick;
        logic [MODE_W-1:0]        m;
        logic signed [DATA_W-1:0] v;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < ins_pct)
            begin
                m = $urandom_range(1) ? MODE_INS_END : MODE_INS_FRONT;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 28)
                    m = MODE_REM_FRONT;
                else if (pick < 56)
                    m = MODE_REM_END;
                else if (pick < 84)
                    m = MODE_REM_AFTER;
                else if (pick < 93)
                    m = MODE_READ_ALL;
                else if (pick < 97)
                    m = MODE_CLEAR;
                else
                    m = MODE_UNUSED;
            end
            v = (m == MODE_REM_AFTER) ? pick_key() : pick_value();
            send_request(m, v);
        end
    endtask

    task automatic finish_run();
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_replies.size() != 0)
        begin
            error_count++;
            $display("%0d replies never arrived", awaited_replies.size());
        end
        $write("covered %0d requests: insert %0d, remove front or end %0d, ",
               mode_tally.sum(), mode_tally[MODE_INS_FRONT] + mode_tally[MODE_INS_END],
               mode_tally[MODE_REM_FRONT] + mode_tally[MODE_REM_END]);
        $display("remove after key %0d, clear %0d, read all %0d, unused %0d",
                 mode_tally[MODE_REM_AFTER], mode_tally[MODE_CLEAR],
                 mode_tally[MODE_READ_ALL], mode_tally[MODE_UNUSED]);
        $display("checked %0d result transactions: ok %0d, full %0d, empty %0d, key missing %0d",
                 reply_count, status_tally[STAT_OK], status_tally[STAT_FULL],
                 status_tally[STAT_EMPTY], status_tally[STAT_NOKEY]);
        if (error_count == 0)
        begin
            $display("tb_circular_list_deque_core passed");
        end
        else
        begin
            $display("tb_circular_list_deque_core failed");
        end
        $finish;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.mode  = MODE_INS_FRONT;
        req_bus.value = '0;
        shadow_head   = '0;
        shadow_count  = '0;
        error_count   = 0;
        reply_count   = 0;
        cycle_count   = 0;
        src_gaps_on   = 1'b1;
        sink_stall_on = 1'b1;
        foreach (mode_tally[i]) mode_tally[i] = 0;
        foreach (status_tally[i]) status_tally[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_list();
        test_field_extremes();
        test_fill_and_full();
        test_random_traffic(120, 42);
        // hold the sender until the block has answered everything
        drain_replies();
        // stretch with no gaps and no stalls
        src_gaps_on   = 1'b0;
        sink_stall_on = 1'b0;
        test_random_traffic(70, 46);
        src_gaps_on   = 1'b1;
        sink_stall_on = 1'b1;
        // insert-heavy so the list runs full and wraps often
        test_random_traffic(90, 62);
        finish_run();
    end

endmodule
